>>> hdl/brl_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package brl_pkg;

   localparam int COL_W      = 7;
   localparam int ROW_W      = 6;
   localparam int INDEX_W    = 9;
   localparam int BIT_POS_W  = 3;
   localparam int ERR_W      = 9;
   localparam int BAND_SHIFT = 3;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_ADVANCE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [COL_W-1:0]   start_x;
      logic [ROW_W-1:0]   start_y;
      logic [COL_W-1:0]   end_x;
      logic [ROW_W-1:0]   end_y;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]     pixel_x;
      logic [ROW_W-1:0]     pixel_y;
      logic [INDEX_W-1:0]   byte_index;
      logic [BIT_POS_W-1:0] bit_position;
      logic                 on_screen;
      logic                 last;
   } rsp_type;

endpackage

>>> hdl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: one beat in, at most one pixel beat out.
//
// A load beat sets up a line; each advance beat emits the current pixel and
// takes one Bresenham step, so the block draws one pixel per clock when the
// source advances every cycle and rsp_stall stays low. Every beat is handled
// in the cycle it is accepted, from the line registers, and its pixel lands in
// a result register backed by a one-entry skid register; req_stall rises only
// while the skid register is full. An advance while idle or a load gives no
// pixel. Off-screen pixels report byte_index 0 with on_screen clear.
module bresenham_line_rasterizer
   import brl_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 84,
   parameter int SCREEN_HEIGHT = 48
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PROD_W = BIT_POS_W + COL_W + 2;
   localparam int CMP_W  = ERR_W + 2;

   logic                    busy_ff,         busy_in;
   logic [COL_W-1:0]        cur_col_ff,      cur_col_in;
   logic [ROW_W-1:0]        cur_row_ff,      cur_row_in;
   logic [COL_W-1:0]        target_col_ff,   target_col_in;
   logic [ROW_W-1:0]        target_row_ff,   target_row_in;
   logic [COL_W-1:0]        delta_col_ff,    delta_col_in;
   logic [ROW_W-1:0]        delta_row_ff,    delta_row_in;
   logic                    col_step_neg_ff, col_step_neg_in;
   logic                    row_step_neg_ff, row_step_neg_in;
   logic [ERR_W-1:0]        error_term_ff,   error_term_in;

   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff,       out_in;
   logic                    skid_valid_ff, skid_valid_in;
   rsp_type                 skid_ff,       skid_in;

   logic                    accept;
   logic                    push;
   logic                    pop;
   logic                    on_scr;
   logic                    at_end;
   logic [PROD_W-1:0]       index_full;
   rsp_type                 pix;
   logic signed [CMP_W-1:0] err_ext;
   logic signed [CMP_W-1:0] err2;
   logic signed [CMP_W-1:0] dcol_ext;
   logic signed [CMP_W-1:0] drow_ext;
   logic signed [CMP_W-1:0] err_next;
   logic                    step_col;
   logic                    step_row;
   logic                    load_col_up;
   logic                    load_row_up;
   logic [COL_W-1:0]        load_dcol;
   logic [ROW_W-1:0]        load_drow;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign push      = accept && (req_data.kind == KIND_ADVANCE) && busy_ff;

   // Pixel for the current position.
   always_comb begin
      on_scr = ({1'b0, cur_col_ff} < (COL_W+1)'(SCREEN_WIDTH)) &&
               ({1'b0, cur_row_ff} < (ROW_W+1)'(SCREEN_HEIGHT));
      index_full = PROD_W'(cur_col_ff) +
                   PROD_W'(cur_row_ff[ROW_W-1:BAND_SHIFT]) * PROD_W'(SCREEN_WIDTH);
      at_end = (cur_col_ff == target_col_ff) && (cur_row_ff == target_row_ff);
      pix.pixel_x      = cur_col_ff;
      pix.pixel_y      = cur_row_ff;
      pix.byte_index   = on_scr ? index_full[INDEX_W-1:0] : '0;
      pix.bit_position = cur_row_ff[BIT_POS_W-1:0];
      pix.on_screen    = on_scr;
      pix.last         = at_end;
   end

   // One Bresenham step.
   always_comb begin
      err_ext  = CMP_W'(signed'(error_term_ff));
      err2     = err_ext <<< 1;
      dcol_ext = CMP_W'(signed'({1'b0, delta_col_ff}));
      drow_ext = CMP_W'(signed'({1'b0, delta_row_ff}));
      step_col = err2 > -drow_ext;
      step_row = err2 < dcol_ext;
      err_next = err_ext - (step_col ? drow_ext : '0) + (step_row ? dcol_ext : '0);
   end

   // Line setup.
   always_comb begin
      load_col_up = req_data.start_x < req_data.end_x;
      load_row_up = req_data.start_y < req_data.end_y;
      load_dcol   = load_col_up ? (req_data.end_x - req_data.start_x)
                                : (req_data.start_x - req_data.end_x);
      load_drow   = load_row_up ? (req_data.end_y - req_data.start_y)
                                : (req_data.start_y - req_data.end_y);
   end

   always_comb begin
      busy_in         = busy_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      target_col_in   = target_col_ff;
      target_row_in   = target_row_ff;
      delta_col_in    = delta_col_ff;
      delta_row_in    = delta_row_ff;
      col_step_neg_in = col_step_neg_ff;
      row_step_neg_in = row_step_neg_ff;
      error_term_in   = error_term_ff;
      if (accept) begin
         unique case (req_data.kind)
            KIND_LOAD: begin
               busy_in         = 1'b1;
               cur_col_in      = req_data.start_x;
               cur_row_in      = req_data.start_y;
               target_col_in   = req_data.end_x;
               target_row_in   = req_data.end_y;
               delta_col_in    = load_dcol;
               delta_row_in    = load_drow;
               col_step_neg_in = !load_col_up;
               row_step_neg_in = !load_row_up;
               error_term_in   = ERR_W'(load_dcol) - ERR_W'(load_drow);
            end
            KIND_ADVANCE: begin
               if (busy_ff) begin
                  if (at_end) begin
                     busy_in = 1'b0;
                  end else begin
                     error_term_in = err_next[ERR_W-1:0];
                     if (step_col) begin
                        cur_col_in = col_step_neg_ff ? (cur_col_ff - 1'b1)
                                                     : (cur_col_ff + 1'b1);
                     end
                     if (step_row) begin
                        cur_row_in = row_step_neg_ff ? (cur_row_ff - 1'b1)
                                                     : (cur_row_ff + 1'b1);
                     end
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   // Result register plus skid entry; push only happens while the skid is empty.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = pix;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = pix;
         end else begin
            out_valid_in = 1'b1;
            out_in       = pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff      <= cur_col_in;
      cur_row_ff      <= cur_row_in;
      target_col_ff   <= target_col_in;
      target_row_ff   <= target_row_in;
      delta_col_ff    <= delta_col_in;
      delta_row_ff    <= delta_row_in;
      col_step_neg_ff <= col_step_neg_in;
      row_step_neg_ff <= row_step_neg_in;
      error_term_ff   <= error_term_in;
      out_ff          <= out_in;
      skid_ff         <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   load_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == KIND_LOAD) |=> busy_ff)
      else $error("load did not start a line");

   last_clears_busy: assert property (@(posedge clock) disable iff (reset)
      push && at_end |=> !busy_ff)
      else $error("line still busy after end point");

   offscreen_index_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.on_screen |-> (out_ff.byte_index == '0))
      else $error("off-screen pixel with nonzero byte index");
`endif

endmodule
